/* rtl/core/mdns_query_packet_builder_defines.svh */
// Assertion macros used by the mDNS query builder checker.
`ifndef MDNS_QUERY_PACKET_BUILDER_DEFINES_SVH
`define MDNS_QUERY_PACKET_BUILDER_DEFINES_SVH

// Same-cycle property, sampled on clk, off while rst is high.
`define MDNSQ_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle property, sampled on clk, off while rst is high.
`define MDNSQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mdnsq_pkg.sv */
// Shared constants, microcode format and program for the mDNS query builder.
`default_nettype none

package mdnsq_pkg;

  localparam int NAME_LIMIT_DEF = 63;
  localparam int LABEL_MAX      = 62;
  localparam int HDR_WORDS      = 6;
  localparam int TAIL_BYTES     = 11;
  localparam int PKT_LEN_W      = 7;
  localparam int QDCOUNT_WORD   = 2;

  localparam logic [7:0]  DOT_CHAR    = 8'h2E;
  localparam logic [15:0] HDR_QDCOUNT = 16'h0002;

  localparam logic [1:0] WB_NONE = 2'd0;
  localparam logic [1:0] WB_HALF = 2'd1;
  localparam logic [1:0] WB_FULL = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CLOSE = 3'd1;
  localparam step_t ST_HDR   = 3'd2;
  localparam step_t ST_READ  = 3'd3;
  localparam step_t ST_BODY  = 3'd4;
  localparam step_t ST_FAIL  = 3'd5;

  typedef enum logic [1:0] {
    EM_NONE = 2'd0,
    EM_HDR  = 2'd1,
    EM_BODY = 2'd2,
    EM_FAIL = 2'd3
  } emit_t;

  typedef enum logic [2:0] {
    CD_ALWAYS   = 3'd0,
    CD_NAME_END = 3'd1,
    CD_FAIL     = 3'd2,
    CD_HDR_LAST = 3'd3,
    CD_PKT_LAST = 3'd4
  } cond_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_t;

  // One control word per program step.
  typedef struct packed {
    logic    in_rdy;
    logic    close;
    logic    rd;
    emit_t   emit;
    cnt_op_t cnt_op;
    logic    name_clr;
    cond_t   cond;
    step_t   jmp;
    step_t   nxt;
  } ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic in_end;
    logic out_free;
    logic fail;
    logic hdr_last;
    logic pkt_last;
  } seq_stat_t;

  typedef struct packed {
    logic done;
    logic take;
  } seq_flow_t;

  function automatic ctl_t prog_word(step_t s);
    ctl_t w;
    w = '0;
    unique case (s)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.cnt_op = CNT_CLR;
        w.cond   = CD_NAME_END;
        w.jmp    = ST_CLOSE;
        w.nxt    = ST_IDLE;
      end
      ST_CLOSE: begin
        w.close  = 1'b1;
        w.cnt_op = CNT_CLR;
        w.cond   = CD_FAIL;
        w.jmp    = ST_FAIL;
        w.nxt    = ST_HDR;
      end
      ST_HDR: begin
        w.emit   = EM_HDR;
        w.cnt_op = CNT_INC;
        w.cond   = CD_HDR_LAST;
        w.jmp    = ST_READ;
        w.nxt    = ST_HDR;
      end
      ST_READ: begin
        w.rd  = 1'b1;
        w.jmp = ST_BODY;
        w.nxt = ST_BODY;
      end
      ST_BODY: begin
        w.emit     = EM_BODY;
        w.cnt_op   = CNT_INC;
        w.name_clr = 1'b1;
        w.cond     = CD_PKT_LAST;
        w.jmp      = ST_IDLE;
        w.nxt      = ST_READ;
      end
      ST_FAIL: begin
        w.emit     = EM_FAIL;
        w.name_clr = 1'b1;
        w.cond     = CD_ALWAYS;
        w.jmp      = ST_IDLE;
        w.nxt      = ST_IDLE;
      end
      default: begin
        w.jmp = ST_IDLE;
        w.nxt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // Bytes after the encoded name: terminator, A/IN, pointer, AAAA/IN.
  function automatic logic [7:0] tail_byte(logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      4'd2, 4'd4, 4'd10: b = 8'h01;
      4'd5:              b = 8'hC0;
      4'd6:              b = 8'h0C;
      4'd8:              b = 8'h1C;
      default:           b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mdnsq_seq.sv */
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module mdnsq_seq
  import mdnsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output ctl_t      ctl,
  output seq_flow_t flow
);

  step_t step;
  step_t step_next;
  logic  cond_hit;

  assign ctl = prog_word(step);

  always_comb begin
    unique case (ctl.cond)
      CD_ALWAYS:   cond_hit = 1'b1;
      CD_NAME_END: cond_hit = stat.in_end;
      CD_FAIL:     cond_hit = stat.fail;
      CD_HDR_LAST: cond_hit = stat.hdr_last;
      CD_PKT_LAST: cond_hit = stat.pkt_last;
      default:     cond_hit = 1'b0;
    endcase
  end

  // A step waits for an input request or for room in the output register.
  assign flow.done = !(ctl.in_rdy && !stat.in_valid) &&
                     !((ctl.emit != EM_NONE) && !stat.out_free);
  assign flow.take = cond_hit;

  always_comb begin
    step_next = step;
    if (flow.done) begin
      step_next = cond_hit ? ctl.jmp : ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mdns_query_packet_builder.sv */
// Top level: mDNS two-question query builder with DNS label encoding.
//
// Input channel (in_valid/in_ready): one host name character per request in
// name_char; name_end marks the final character. Dots separate labels and
// empty labels are dropped. Characters are taken one per cycle while idle.
// Output channel (out_valid/out_ready): after the final character the block
// sends the query as 16-bit words (earlier byte high), word_bytes gives the
// valid bytes, packet_length the packet size, last_word flags the end. A
// name that cannot be encoded gives one request with failed set instead.
// After the last character is taken, the CLOSE step closes the open label;
// the HDR step (or the FAIL step) then loads the first header word (or the
// failure request) into the output register. Six header words go out one per
// cycle while the receiver takes them; each name/trailer word needs a store
// read step and then an output load step. The name store read and the output
// register set the word rate. No new name is taken until the last word has
// been loaded into the output register.
// Reset clears the label state and out_valid but not the output data; the
// name store is not cleared, it is always written before it is read. When the
// receiver stalls, the current word holds and the sequencer waits on that step.
`default_nettype none

module mdns_query_packet_builder
  import mdnsq_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  name_char,
  input  logic        name_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] packet_word,
  output logic [1:0]  word_bytes,
  output logic [6:0]  packet_length,
  output logic        failed,
  output logic        last_word
);

  localparam int DEPTH     = NAME_LIMIT + 1;
  localparam int AW        = $clog2(DEPTH);
  localparam int WORDS_MAX = (NAME_LIMIT + 2 * HDR_WORDS + TAIL_BYTES + 1) / 2;
  localparam int WCW       = $clog2(WORDS_MAX + 1);
  localparam int PW        = WCW + 1;
  localparam int OW        = (PW > PKT_LEN_W) ? PW : PKT_LEN_W;
  localparam int LIMIT_M1  = NAME_LIMIT - 1;

  ctl_t      ctl;
  seq_flow_t flow;
  seq_stat_t stat;

  logic [7:0]    name_store [DEPTH];
  logic [AW-1:0] enc, enc_next;
  logic [AW-1:0] slot, slot_next;
  logic [5:0]    lcnt, lcnt_next;
  logic          too_long, too_long_next;
  logic [WCW-1:0] wcnt;

  logic          accept;
  logic          is_dot;
  logic          close_req;
  logic          room_new, room_one;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic [PW-1:0] kk, p0, p1, encp, end_pos, t0, t1;
  logic          in0, in1;
  logic [AW-1:0] ra0, ra1;
  logic [7:0]    rd0, rd1, b0, b1;
  logic          pkt_last, two_bytes;
  logic [OW-1:0] pkt_len;
  logic          load;

  mdnsq_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl),
    .flow (flow)
  );

  assign in_ready = ctl.in_rdy && !rst;
  assign accept   = in_valid && in_ready;
  assign is_dot   = (name_char == DOT_CHAR);

  assign room_new = ({1'b0, enc} + (AW+1)'(2)) <= (AW+1)'(LIMIT_M1);
  assign room_one = ({1'b0, enc} + (AW+1)'(1)) <= (AW+1)'(LIMIT_M1);

  // Label encoder: one store write per cycle at most.
  always_comb begin
    enc_next      = enc;
    slot_next     = slot;
    lcnt_next     = lcnt;
    too_long_next = too_long;
    wr_en         = 1'b0;
    wr_addr       = enc;
    wr_data       = name_char;
    close_req     = (accept && is_dot) || ctl.close;
    if (close_req) begin
      if (lcnt != 6'd0) begin
        wr_en     = 1'b1;
        wr_addr   = slot;
        wr_data   = {2'b00, lcnt};
        lcnt_next = 6'd0;
      end
    end else if (accept && !too_long) begin
      if (lcnt == 6'd0) begin
        // new label: length byte slot plus first character
        if (!room_new) begin
          too_long_next = 1'b1;
        end else begin
          slot_next = enc;
          wr_en     = 1'b1;
          wr_addr   = enc + AW'(1);
          enc_next  = enc + AW'(2);
          lcnt_next = 6'd1;
        end
      end else if (lcnt >= 6'(LABEL_MAX) || !room_one) begin
        too_long_next = 1'b1;
      end else begin
        wr_en     = 1'b1;
        enc_next  = enc + AW'(1);
        lcnt_next = lcnt + 6'd1;
      end
    end
    if (flow.done && flow.take && ctl.name_clr) begin
      enc_next      = '0;
      slot_next     = '0;
      lcnt_next     = 6'd0;
      too_long_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc      <= '0;
      slot     <= '0;
      lcnt     <= 6'd0;
      too_long <= 1'b0;
    end else begin
      enc      <= enc_next;
      slot     <= slot_next;
      lcnt     <= lcnt_next;
      too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_store[wr_addr] <= wr_data;
    end
  end

  // Name-relative byte positions of the current body word.
  assign kk      = PW'(wcnt) - PW'(HDR_WORDS);
  assign p0      = {kk[PW-2:0], 1'b0};
  assign p1      = p0 | PW'(1);
  assign encp    = PW'(enc);
  assign end_pos = encp + PW'(TAIL_BYTES);
  assign in0     = p0 < encp;
  assign in1     = p1 < encp;
  assign ra0     = in0 ? p0[AW-1:0] : '0;
  assign ra1     = in1 ? p1[AW-1:0] : '0;
  assign t0      = p0 - encp;
  assign t1      = p1 - encp;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd0 <= name_store[ra0];
      rd1 <= name_store[ra1];
    end
  end

  assign b0        = in0 ? rd0 : tail_byte(t0[3:0]);
  assign b1        = in1 ? rd1 : tail_byte(t1[3:0]);
  assign pkt_last  = (p0 + PW'(2)) >= end_pos;
  assign two_bytes = p1 < end_pos;
  assign pkt_len   = OW'(enc) + OW'(2 * HDR_WORDS + TAIL_BYTES);

  assign stat.in_valid = in_valid && !rst;
  assign stat.in_end   = name_end;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.fail     = too_long || (enc == '0);
  assign stat.hdr_last = (wcnt == WCW'(HDR_WORDS - 1));
  assign stat.pkt_last = pkt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
    end else begin
      case (ctl.cnt_op)
        CNT_CLR: wcnt <= '0;
        CNT_INC: if (flow.done) wcnt <= wcnt + WCW'(1);
        default: wcnt <= wcnt;
      endcase
    end
  end

  assign load = flow.done && (ctl.emit != EM_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (ctl.emit)
        EM_HDR: begin
          packet_word   <= (wcnt == WCW'(QDCOUNT_WORD)) ? HDR_QDCOUNT : 16'h0000;
          word_bytes    <= WB_FULL;
          packet_length <= pkt_len[6:0];
          failed        <= 1'b0;
          last_word     <= 1'b0;
        end
        EM_BODY: begin
          packet_word   <= {b0, two_bytes ? b1 : 8'h00};
          word_bytes    <= two_bytes ? WB_FULL : WB_HALF;
          packet_length <= pkt_len[6:0];
          failed        <= 1'b0;
          last_word     <= pkt_last;
        end
        EM_FAIL: begin
          packet_word   <= 16'h0000;
          word_bytes    <= WB_NONE;
          packet_length <= 7'd0;
          failed        <= 1'b1;
          last_word     <= 1'b1;
        end
        default: begin
          packet_word   <= packet_word;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mdnsq_checker.sv */
// Port-level checker for the mDNS query builder, bound to the top level.
`default_nettype none
`include "mdns_query_packet_builder_defines.svh"

module mdnsq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        name_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] packet_word,
  input logic [1:0]  word_bytes,
  input logic [6:0]  packet_length,
  input logic        failed,
  input logic        last_word
);

  // failure is a single closing request with no length
  `MDNSQ_CHECK(a_fail_shape, out_valid && failed, last_word && (packet_length == 7'd0), "failure request malformed")

  // only the final word of a packet may be short
  `MDNSQ_CHECK(a_full_words, out_valid && !failed && !last_word, word_bytes == 2'd2, "short word before packet end")

  // a name end starts packet building; no character is taken next cycle
  `MDNSQ_CHECK_NEXT(a_end_blocks, in_valid && in_ready && name_end, !in_ready, "input taken right after name end")

  `MDNSQ_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packet_word), "stalled output changed")

endmodule

bind mdns_query_packet_builder mdnsq_checker u_mdnsq_checker (.*);

`default_nettype wire
